>>> rtl/core/lzssd_pkg.sv
// Shared types and constants of the LZSS decompressor.
`default_nettype none
package lzssd_pkg;

  localparam int INDEX_BITS    = 13;
  localparam int LENGTH_BITS   = 4;
  localparam int BYTE_BITS     = 8;
  localparam int WIN_SIZE      = 1 << INDEX_BITS;
  localparam int BREAK_EVEN    = (1 + INDEX_BITS + LENGTH_BITS) / 9;
  localparam int MAX_COPY      = (1 << LENGTH_BITS) - 1 + BREAK_EVEN + 1;
  localparam int CNT_W         = $clog2(MAX_COPY + 1);
  localparam int FIELD_MAX     = (INDEX_BITS > BYTE_BITS) ? INDEX_BITS : BYTE_BITS;
  localparam int REM_W         = $clog2(FIELD_MAX + 1);
  localparam int BCNT_W        = $clog2(BYTE_BITS + 1);
  localparam int OQ_DEPTH      = 4;
  localparam int OQ_AW         = $clog2(OQ_DEPTH);
  localparam int OQ_CW         = $clog2(OQ_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_LIT,
    CMD_MATCH,
    CMD_END
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                kind;
    logic [BYTE_BITS-1:0]     lit;
    logic [INDEX_BITS-1:0]    pos;
    logic [LENGTH_BITS-1:0]   len;
  } cmd_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0] data;
    logic                 byte_valid;
    logic                 last;
    logic                 stream_end;
  } out_t;

endpackage
`default_nettype wire

>>> rtl/core/lzssd_front.sv
// Bit parser: takes compressed bytes and turns completed tokens into commands.
`default_nettype none
module lzssd_front (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_push,
  input  wire logic [lzssd_pkg::BYTE_BITS-1:0]    in_byte,
  output logic                                    in_full,
  output logic                                    cmd_push,
  output lzssd_pkg::cmd_t                         cmd,
  input  wire logic                               cmd_full
);

  typedef enum logic [1:0] {
    PH_FLAG,
    PH_LIT,
    PH_IDX,
    PH_LEN
  } phase_t;

  phase_t                                 phase_r, phase_nxt;
  logic [lzssd_pkg::INDEX_BITS-1:0]       shift_r, shift_nxt;
  logic [lzssd_pkg::REM_W-1:0]            rem_r, rem_nxt;
  logic [lzssd_pkg::INDEX_BITS-1:0]       mpos_r, mpos_nxt;
  logic                                   fin_r, fin_nxt;
  logic [lzssd_pkg::BYTE_BITS-1:0]        byte_r, byte_nxt;
  logic [lzssd_pkg::BCNT_W-1:0]           bcnt_r, bcnt_nxt;

  logic                                   busy;
  logic                                   adv;
  logic                                   stop;
  logic                                   completes;
  logic                                   step_last;
  logic [lzssd_pkg::INDEX_BITS-1:0]       sh;
  logic [lzssd_pkg::REM_W-1:0]            rem_dec;

  assign busy    = (bcnt_r != '0);
  assign sh      = {shift_r[lzssd_pkg::INDEX_BITS-2:0], byte_r[lzssd_pkg::BYTE_BITS-1]};
  assign rem_dec = (rem_r != '0) ? rem_r - 1'b1 : '0;

  // a token closes on this bit and needs a command slot
  always_comb begin
    completes = 1'b0;
    if (busy && !fin_r && rem_dec == '0) begin
      unique case (phase_r)
        PH_LIT:  completes = 1'b1;
        PH_LEN:  completes = 1'b1;
        PH_IDX:  completes = (sh == '0);
        PH_FLAG: completes = 1'b0;
        default: completes = 1'b0;
      endcase
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    shift_nxt = shift_r;
    rem_nxt   = rem_r;
    mpos_nxt  = mpos_r;
    fin_nxt   = fin_r;
    byte_nxt  = byte_r;
    bcnt_nxt  = bcnt_r;
    cmd_push  = 1'b0;
    cmd       = '0;
    adv       = 1'b0;
    stop      = 1'b0;

    if (busy) begin
      if (fin_r) begin
        stop = 1'b1;
      end else if (!completes || !cmd_full) begin
        adv = 1'b1;
        unique case (phase_r)
          PH_FLAG: begin
            shift_nxt = '0;
            if (byte_r[lzssd_pkg::BYTE_BITS-1]) begin
              rem_nxt   = lzssd_pkg::REM_W'(lzssd_pkg::BYTE_BITS);
              phase_nxt = PH_LIT;
            end else begin
              rem_nxt   = lzssd_pkg::REM_W'(lzssd_pkg::INDEX_BITS);
              phase_nxt = PH_IDX;
            end
          end
          PH_LIT, PH_IDX, PH_LEN: begin
            shift_nxt = sh;
            rem_nxt   = rem_dec;
            if (rem_dec == '0) begin
              if (phase_r == PH_LIT) begin
                cmd_push  = 1'b1;
                cmd.kind  = lzssd_pkg::CMD_LIT;
                cmd.lit   = sh[lzssd_pkg::BYTE_BITS-1:0];
                phase_nxt = PH_FLAG;
              end else if (phase_r == PH_IDX) begin
                if (sh == '0) begin
                  cmd_push  = 1'b1;
                  cmd.kind  = lzssd_pkg::CMD_END;
                  fin_nxt   = 1'b1;
                  stop      = 1'b1;
                  phase_nxt = PH_FLAG;
                end else begin
                  mpos_nxt  = sh;
                  shift_nxt = '0;
                  rem_nxt   = lzssd_pkg::REM_W'(lzssd_pkg::LENGTH_BITS);
                  phase_nxt = PH_LEN;
                end
              end else begin
                cmd_push  = 1'b1;
                cmd.kind  = lzssd_pkg::CMD_MATCH;
                cmd.pos   = mpos_r;
                cmd.len   = sh[lzssd_pkg::LENGTH_BITS-1:0];
                phase_nxt = PH_FLAG;
              end
            end
          end
          default: phase_nxt = PH_FLAG;
        endcase
      end
    end

    if (adv) begin
      byte_nxt = {byte_r[lzssd_pkg::BYTE_BITS-2:0], 1'b0};
      bcnt_nxt = bcnt_r - 1'b1;
    end
    // rest of the byte after end of stream is dropped
    if (stop) begin
      bcnt_nxt = '0;
    end

    step_last = busy && (stop || (adv && bcnt_r == lzssd_pkg::BCNT_W'(1)));
    in_full   = busy && !step_last;

    if (in_push && !in_full) begin
      byte_nxt = in_byte;
      bcnt_nxt = fin_nxt ? '0 : lzssd_pkg::BCNT_W'(lzssd_pkg::BYTE_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FLAG;
      shift_r <= '0;
      rem_r   <= '0;
      mpos_r  <= '0;
      fin_r   <= 1'b0;
      bcnt_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      shift_r <= shift_nxt;
      rem_r   <= rem_nxt;
      mpos_r  <= mpos_nxt;
      fin_r   <= fin_nxt;
      bcnt_r  <= bcnt_nxt;
    end
    byte_r <= byte_nxt;
  end

endmodule
`default_nettype wire

>>> rtl/core/lzssd_cmd_q.sv
// Two-entry command queue between parser and copy engine.
`default_nettype none
module lzssd_cmd_q (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire lzssd_pkg::cmd_t   wdata,
  output logic                   full,
  output logic                   valid,
  output lzssd_pkg::cmd_t        rdata,
  input  wire logic              pop
);

  lzssd_pkg::cmd_t  mem_r [2];
  logic             wptr_r, wptr_nxt;
  logic             rptr_r, rptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == 2'd2);
  assign valid   = (cnt_r != 2'd0);
  assign rdata   = mem_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wptr_nxt = wptr_r ^ do_push;
    rptr_nxt = rptr_r ^ do_pop;
    cnt_nxt  = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/lzssd_back.sv
// Copy engine: window memory, literal/match expansion and the result queue.
`default_nettype none
module lzssd_back (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cmd_valid,
  input  wire lzssd_pkg::cmd_t                    cmd,
  output logic                                    cmd_pop,
  output logic                                    out_empty,
  input  wire logic                               out_pop,
  output lzssd_pkg::out_t                         out_item
);

  // issue stage
  logic                                   s1_v_r, s1_v_nxt;
  lzssd_pkg::cmd_kind_t                   s1_kind_r, s1_kind_nxt;
  logic [lzssd_pkg::INDEX_BITS-1:0]       s1_pos_r, s1_pos_nxt;
  logic [lzssd_pkg::BYTE_BITS-1:0]        s1_imm_r, s1_imm_nxt;
  logic [lzssd_pkg::CNT_W-1:0]            s1_cnt_r, s1_cnt_nxt;
  logic [lzssd_pkg::INDEX_BITS-1:0]       s1_pos_inc;

  // data stage
  logic                                   s2_v_r;
  logic                                   s2_mem_r;
  logic                                   s2_wr_r;
  lzssd_pkg::out_t                        s2_item_r, s2_item_nxt;
  logic                                   s2_mem_nxt;
  logic                                   s2_wr_nxt;
  logic [lzssd_pkg::BYTE_BITS-1:0]        s2_data;

  logic [lzssd_pkg::INDEX_BITS-1:0]       wp_r;
  logic [lzssd_pkg::BYTE_BITS-1:0]        win_mem [lzssd_pkg::WIN_SIZE];
  logic [lzssd_pkg::BYTE_BITS-1:0]        rd_q_r;
  logic                                   fwd_hit_r;
  logic [lzssd_pkg::BYTE_BITS-1:0]        fwd_r;
  logic                                   win_we;

  lzssd_pkg::out_t                        oq_r [lzssd_pkg::OQ_DEPTH];
  logic [lzssd_pkg::OQ_AW-1:0]            oq_wptr_r;
  logic [lzssd_pkg::OQ_AW-1:0]            oq_rptr_r;
  logic [lzssd_pkg::OQ_CW-1:0]            oq_cnt_r;
  logic                                   oq_pop;
  logic                                   room;
  logic                                   issue;
  logic                                   s1_done;

  lzssd_wrap u_wrap (
    .pos  (s1_pos_r),
    .ofs  (lzssd_pkg::CNT_W'(1)),
    .addr (s1_pos_inc)
  );

  // keep a slot for the byte already in the data stage
  assign room    = (oq_cnt_r + lzssd_pkg::OQ_CW'(s2_v_r)) <
                   lzssd_pkg::OQ_CW'(lzssd_pkg::OQ_DEPTH);
  assign issue   = s1_v_r && room;
  assign s1_done = issue && (s1_cnt_r == lzssd_pkg::CNT_W'(1));
  assign cmd_pop = cmd_valid && (!s1_v_r || s1_done);

  always_comb begin
    s1_v_nxt    = s1_v_r;
    s1_kind_nxt = s1_kind_r;
    s1_pos_nxt  = s1_pos_r;
    s1_imm_nxt  = s1_imm_r;
    s1_cnt_nxt  = s1_cnt_r;
    if (issue) begin
      s1_pos_nxt = s1_pos_inc;
      s1_cnt_nxt = s1_cnt_r - 1'b1;
      if (s1_done) begin
        s1_v_nxt = 1'b0;
      end
    end
    if (cmd_pop) begin
      s1_v_nxt    = 1'b1;
      s1_kind_nxt = cmd.kind;
      s1_pos_nxt  = cmd.pos;
      s1_imm_nxt  = cmd.lit;
      if (cmd.kind == lzssd_pkg::CMD_MATCH) begin
        s1_cnt_nxt = lzssd_pkg::CNT_W'(cmd.len) +
                     lzssd_pkg::CNT_W'(lzssd_pkg::BREAK_EVEN + 1);
      end else begin
        s1_cnt_nxt = lzssd_pkg::CNT_W'(1);
      end
    end
  end

  always_comb begin
    s2_item_nxt      = '0;
    s2_mem_nxt       = 1'b0;
    s2_wr_nxt        = 1'b0;
    s2_item_nxt.last = (s1_cnt_r == lzssd_pkg::CNT_W'(1));
    unique case (s1_kind_r)
      lzssd_pkg::CMD_LIT: begin
        s2_item_nxt.data       = s1_imm_r;
        s2_item_nxt.byte_valid = 1'b1;
        s2_wr_nxt              = 1'b1;
      end
      lzssd_pkg::CMD_MATCH: begin
        s2_item_nxt.byte_valid = 1'b1;
        s2_mem_nxt             = 1'b1;
        s2_wr_nxt              = 1'b1;
      end
      lzssd_pkg::CMD_END: begin
        s2_item_nxt.stream_end = 1'b1;
      end
      default: begin
        s2_item_nxt.stream_end = 1'b1;
      end
    endcase
  end

  // a read that hits the address written in the same cycle takes the new byte
  assign s2_data = s2_mem_r ? (fwd_hit_r ? fwd_r : rd_q_r) : s2_item_r.data;
  assign win_we  = s2_v_r && s2_wr_r;

  always_ff @(posedge clk) begin
    if (win_we) begin
      win_mem[wp_r] <= s2_data;
    end
    rd_q_r <= win_mem[s1_pos_r];
  end

  assign oq_pop    = out_pop && !out_empty;
  assign out_empty = (oq_cnt_r == '0);
  assign out_item  = oq_r[oq_rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      wp_r      <= lzssd_pkg::INDEX_BITS'(1);
      fwd_hit_r <= 1'b0;
      oq_wptr_r <= '0;
      oq_rptr_r <= '0;
      oq_cnt_r  <= '0;
    end else begin
      s1_v_r    <= s1_v_nxt;
      s2_v_r    <= issue;
      fwd_hit_r <= win_we && (wp_r == s1_pos_r);
      if (win_we) begin
        wp_r <= wp_r + 1'b1;
      end
      if (s2_v_r) begin
        oq_wptr_r <= oq_wptr_r + 1'b1;
      end
      if (oq_pop) begin
        oq_rptr_r <= oq_rptr_r + 1'b1;
      end
      oq_cnt_r <= oq_cnt_r + lzssd_pkg::OQ_CW'(s2_v_r) - lzssd_pkg::OQ_CW'(oq_pop);
    end
    s1_kind_r <= s1_kind_nxt;
    s1_pos_r  <= s1_pos_nxt;
    s1_imm_r  <= s1_imm_nxt;
    s1_cnt_r  <= s1_cnt_nxt;
    s2_item_r <= s2_item_nxt;
    s2_mem_r  <= s2_mem_nxt;
    s2_wr_r   <= s2_wr_nxt;
    fwd_r     <= s2_data;
    if (s2_v_r) begin
      oq_r[oq_wptr_r] <= '{data:       s2_data,
                           byte_valid: s2_item_r.byte_valid,
                           last:       s2_item_r.last,
                           stream_end: s2_item_r.stream_end};
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/lzssd_bitstream_decompressor_top_note.sv
// Window address helper: wraps a match source position around the window.
`default_nettype none
module lzssd_wrap (
  input  wire logic [lzssd_pkg::INDEX_BITS-1:0] pos,
  input  wire logic [lzssd_pkg::CNT_W-1:0]      ofs,
  output logic [lzssd_pkg::INDEX_BITS-1:0]      addr
);

  assign addr = pos + lzssd_pkg::INDEX_BITS'(ofs);

endmodule
`default_nettype wire

>>> rtl/core/lzss_bitstream_decompressor.sv
// LZSS decompressor (13-bit window index, 4-bit length), top level.
//
// Input: compressed bytes on in_byte, taken when in_push is high and in_full
// is low. Bits are read MSB first, one bit per cycle while the command queue
// has room, and in_full drops while the last bit of a byte is read, so the
// next byte can be taken as that last bit is consumed.
// Output: queue-style; while out_empty is low the oldest result sits on the
// out_ ports and leaves on a cycle with out_pop high. A literal goes from the
// parser through the command queue, issue and data stages to the result queue;
// a match of N bytes streams one byte per cycle, while the result queue has
// room, from the 8 KiB window memory (read port, same-cycle write forward).
// out_last marks the final result caused by one input byte; the end-of-stream
// token gives one item with out_stream_end high and out_byte_valid low, and
// all later input is taken and dropped until reset.
// A stall on out_pop fills the 4-entry result queue, then the copy engine,
// then the 2-entry command queue, and finally holds in_full high.
// Reset (rst_n low, synchronous) empties all queues, sets the write position
// to 1 and starts a new stream; the window contents are not cleared.
`default_nettype none
module lzss_bitstream_decompressor (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_push,
  input  wire logic [lzssd_pkg::BYTE_BITS-1:0]  in_byte,
  output logic                                  in_full,
  output logic                                  out_empty,
  input  wire logic                             out_pop,
  output logic [lzssd_pkg::BYTE_BITS-1:0]       out_byte,
  output logic                                  out_byte_valid,
  output logic                                  out_last,
  output logic                                  out_stream_end
);

  logic             cmd_push;
  logic             cmd_full;
  logic             cmd_valid;
  logic             cmd_pop;
  lzssd_pkg::cmd_t  cmd_w;
  lzssd_pkg::cmd_t  cmd_r;
  lzssd_pkg::out_t  out_item;

  lzssd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_byte  (in_byte),
    .in_full  (in_full),
    .cmd_push (cmd_push),
    .cmd      (cmd_w),
    .cmd_full (cmd_full)
  );

  lzssd_cmd_q u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_w),
    .full  (cmd_full),
    .valid (cmd_valid),
    .rdata (cmd_r),
    .pop   (cmd_pop)
  );

  lzssd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd_r),
    .cmd_pop   (cmd_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  assign out_byte       = out_item.data;
  assign out_byte_valid = out_item.byte_valid;
  assign out_last       = out_item.last;
  assign out_stream_end = out_item.stream_end;

`ifndef NO_ASSERTIONS
  a_cmd_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push |-> !cmd_full)
    else $error("command pushed into full queue");

  a_cmd_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_valid)
    else $error("command popped from empty queue");

  a_end_marker: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_stream_end) |-> (out_last && !out_byte_valid))
    else $error("end marker not last or flagged as data");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("block not idle after reset");
`endif

endmodule
`default_nettype wire

>>> test/tb_lzss_bitstream_decompressor.sv
// Testbench for the LZSS bitstream decompressor: stream generator, scoreboard, drivers.
`timescale 1ns / 1ps

module tb_lzss_bitstream_decompressor;

  localparam int CLK_PERIOD    = 12;
  localparam int RESET_CYCLES  = 9;
  localparam int STREAM_BYTES  = 216;
  localparam int TAIL_BYTES    = 4;
  localparam int HOLD_CYCLES   = 300;
  localparam int HOLD_AFTER_IN = 48;
  localparam int DRAIN_CYCLES  = 64;
  localparam int STALL_LIMIT   = 4000;

  typedef enum logic [1:0] {TOK_FLAG, TOK_LIT, TOK_IDX, TOK_LEN} tok_phase_t;

  // Decodes accepted bytes into the output items they must produce and
  // compares them against what the block delivers.
  class lzss_decode_sb_t;
    bit [7:0]                       window [lzssd_pkg::WIN_SIZE];
    bit [lzssd_pkg::INDEX_BITS-1:0] wr_pos;
    tok_phase_t                     phase;
    bit [lzssd_pkg::INDEX_BITS-1:0] shreg;
    int unsigned                    bits_left;
    bit [lzssd_pkg::INDEX_BITS-1:0] copy_src;
    bit                             stopped;
    lzssd_pkg::out_t                pending_out[$];
    int                             errors;
    int                             n_lit;
    int                             n_copy;
    int                             n_end;
    int                             n_checked;

    function new();
      wr_pos    = lzssd_pkg::INDEX_BITS'(1);
      phase     = TOK_FLAG;
      shreg     = '0;
      bits_left = 0;
      copy_src  = '0;
      stopped   = 1'b0;
      errors    = 0;
      n_lit     = 0;
      n_copy    = 0;
      n_end     = 0;
      n_checked = 0;
    endfunction

    function void emit_byte(bit [7:0] c);
      lzssd_pkg::out_t e;
      e.data       = c;
      e.byte_valid = 1'b1;
      e.last       = 1'b0;
      e.stream_end = 1'b0;
      pending_out.push_back(e);
      window[wr_pos] = c;
      wr_pos++;
    endfunction

    function void decode_byte(bit [7:0] b);
      int unsigned                    first;
      int unsigned                    cnt;
      bit [lzssd_pkg::INDEX_BITS-1:0] idx;
      lzssd_pkg::out_t                e;
      first = pending_out.size();
      if (stopped) return;
      for (int i = 7; i >= 0 && !stopped; i--) begin
        if (phase == TOK_FLAG) begin
          shreg = '0;
          if (b[i]) begin
            bits_left = lzssd_pkg::BYTE_BITS;
            phase = TOK_LIT;
          end else begin
            bits_left = lzssd_pkg::INDEX_BITS;
            phase = TOK_IDX;
          end
        end else begin
          shreg = {shreg[lzssd_pkg::INDEX_BITS-2:0], b[i]};
          bits_left--;
          if (bits_left == 0) begin
            unique case (phase)
              TOK_LIT: begin
                emit_byte(shreg[7:0]);
                n_lit++;
                phase = TOK_FLAG;
              end
              TOK_IDX: begin
                if (shreg == '0) begin
                  e.data       = '0;
                  e.byte_valid = 1'b0;
                  e.last       = 1'b0;
                  e.stream_end = 1'b1;
                  pending_out.push_back(e);
                  n_end++;
                  stopped = 1'b1;
                  phase = TOK_FLAG;
                end else begin
                  copy_src  = shreg;
                  shreg     = '0;
                  bits_left = lzssd_pkg::LENGTH_BITS;
                  phase = TOK_LEN;
                end
              end
              default: begin
                cnt = shreg[lzssd_pkg::LENGTH_BITS-1:0] + lzssd_pkg::BREAK_EVEN + 1;
                // source may overlap bytes this copy has just written
                for (int k = 0; k < cnt; k++) begin
                  idx = copy_src + k[lzssd_pkg::INDEX_BITS-1:0];
                  emit_byte(window[idx]);
                end
                n_copy++;
                phase = TOK_FLAG;
              end
            endcase
          end
        end
      end
      if (pending_out.size() > first) begin
        e = pending_out.pop_back();
        e.last = 1'b1;
        pending_out.push_back(e);
      end
    endfunction

    function void compare_output(bit [7:0] d, bit v, bit l, bit s);
      lzssd_pkg::out_t e;
      if (pending_out.size() == 0) begin
        $error("unexpected result: out_byte=%0h byte_valid=%0b last=%0b stream_end=%0b",
               d, v, l, s);
        errors++;
        return;
      end
      e = pending_out.pop_front();
      n_checked++;
      if (d != e.data) begin
        $error("out_byte: expected %0h, actual %0h", e.data, d);
        errors++;
      end
      if (v != e.byte_valid) begin
        $error("out_byte_valid: expected %0b, actual %0b", e.byte_valid, v);
        errors++;
      end
      if (l != e.last) begin
        $error("out_last: expected %0b, actual %0b", e.last, l);
        errors++;
      end
      if (s != e.stream_end) begin
        $error("out_stream_end: expected %0b, actual %0b", e.stream_end, s);
        errors++;
      end
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_push = 1'b0;
  logic [lzssd_pkg::BYTE_BITS-1:0] in_byte = '0;
  logic                            in_full;
  logic                            out_empty;
  logic                            out_pop = 1'b0;
  logic [lzssd_pkg::BYTE_BITS-1:0] out_byte;
  logic                            out_byte_valid;
  logic                            out_last;
  logic                            out_stream_end;

  lzss_decode_sb_t sb;

  bit [7:0] stream_q[$];
  bit [7:0] pack_acc;
  int       pack_cnt;
  int       gen_wp;

  int n_in;
  int idle_cycles;
  int full_cycles;
  bit moved;
  bit draining;
  bit held_off;

  lzss_bitstream_decompressor dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_byte        (in_byte),
    .in_full        (in_full),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_last       (out_last),
    .out_stream_end (out_stream_end)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Packs token fields MSB first into the compressed byte stream.
  task automatic put_bits(input int value, input int n);
    for (int i = n - 1; i >= 0; i--) begin
      pack_acc = {pack_acc[6:0], value[i]};
      pack_cnt++;
      if (pack_cnt == 8) begin
        stream_q.push_back(pack_acc);
        pack_cnt = 0;
      end
    end
  endtask

  task automatic add_literal(input int c);
    put_bits(1, 1);
    put_bits(c, lzssd_pkg::BYTE_BITS);
    gen_wp++;
  endtask

  // pos must point into the already written part of the window
  task automatic add_copy(input int pos, input int len);
    put_bits(0, 1);
    put_bits(pos, lzssd_pkg::INDEX_BITS);
    put_bits(len, lzssd_pkg::LENGTH_BITS);
    gen_wp += len + lzssd_pkg::BREAK_EVEN + 1;
  endtask

  task automatic build_stream();
    int back;
    int reach;
    gen_wp   = 1;
    pack_cnt = 0;
    pack_acc = '0;
    add_literal('h00);
    add_literal('hFF);
    add_literal('h80);
    add_literal('h7F);
    add_copy(1, 0);
    add_copy(gen_wp - 1, 15);   // run from the previous byte
    add_copy(2, 15);
    add_literal('hA5);
    add_copy(gen_wp - 2, 4);
    add_copy(1, 7);
    while (stream_q.size() < STREAM_BYTES) begin
      if ($urandom_range(0, 9) < 4) begin
        add_literal($urandom_range(0, 255));
      end else if ($urandom_range(0, 3) != 0) begin
        reach = (gen_wp - 2 < 24) ? gen_wp - 2 : 24;
        back = $urandom_range(0, reach);
        add_copy(gen_wp - 1 - back, $urandom_range(0, 15));
      end else begin
        add_copy($urandom_range(1, gen_wp - 1), $urandom_range(0, 15));
      end
    end
    // end token; rest of its byte and the bytes after it are don't-care
    put_bits(0, 1);
    put_bits(0, lzssd_pkg::INDEX_BITS);
    while (pack_cnt != 0) put_bits($urandom_range(0, 1), 1);
    repeat (TAIL_BYTES) stream_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // Accepts and checks requests on both sides; also the stall watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      moved = 1'b0;
      if (in_push && !in_full) begin
        sb.decode_byte(in_byte);
        n_in++;
        moved = 1'b1;
      end
      if (in_push && in_full) full_cycles++;
      if (out_pop && !out_empty) begin
        sb.compare_output(out_byte, out_byte_valid, out_last, out_stream_end);
        moved = 1'b1;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb_lzss_bitstream_decompressor: errors");
        $finish;
      end
    end
  end

  // Receiver: stretches of steady, random and sparse pops, one long hold-off.
  initial begin
    int mode;
    int span;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (draining) begin
        out_pop <= 1'b1;
        @(posedge clk);
      end else if (!held_off && n_in >= HOLD_AFTER_IN) begin
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held_off = 1'b1;
      end else begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(10, 80);
        for (int j = 0; j < span && !draining; j++) begin
          unique case (mode)
            0:       out_pop <= 1'b1;
            1:       out_pop <= 1'($urandom_range(0, 1));
            default: out_pop <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // Sender: bursts of requests separated by random gaps.
  initial begin
    int burst_left;
    int gap;
    sb = new();
    n_in = 0;
    idle_cycles = 0;
    full_cycles = 0;
    draining = 1'b0;
    held_off = 1'b0;
    burst_left = 0;
    build_stream();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (stream_q[i]) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
        burst_left = $urandom_range(1, 16);
        if (gap > 0) begin
          in_push <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
      in_push <= 1'b1;
      in_byte <= stream_q[i];
      do @(posedge clk); while (in_full);
    end
    in_push <= 1'b0;
    @(posedge clk);
    draining = 1'b1;
    while (sb.pending_out.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Fed %0d compressed bytes: %0d literals, %0d copies, %0d end marker(s);",
             n_in, sb.n_lit, sb.n_copy, sb.n_end);
    $display("%0d items checked; input was back-pressured for %0d cycles.",
             sb.n_checked, full_cycles);
    if (sb.errors == 0) begin
      $display("tb_lzss_bitstream_decompressor: clean");
    end else begin
      $display("tb_lzss_bitstream_decompressor: errors");
    end
    $finish;
  end

endmodule
